// File: hdl/sma_crossover_detector_assert.svh
// Assertion macros shared by the moving average crossover RTL.
`ifndef SMA_CROSSOVER_DETECTOR_ASSERT_SVH
`define SMA_CROSSOVER_DETECTOR_ASSERT_SVH

// Condition holds in the same cycle; uses clk and rst_n of the enclosing module.
`define SMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the next cycle.
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sma_pkg.sv
// Shared constants, types and helpers of the moving average crossover block.
package sma_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int PRICE_BITS   = 40;
  localparam int CFG_W        = 7;
  localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = PRICE_BITS + ADDR_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

  // Configuration register indexes.
  localparam logic [0:0] REG_SHORT_LENGTH = 1'b0;
  localparam logic [0:0] REG_LONG_LENGTH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_S,
    ST_DIV_L,
    ST_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  // Divider status back to the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // A length of zero counts as one, and one above the window depth as the depth.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (v == '0) begin
      res = LEN_W'(1);
    end else if (int'(v) > WINDOW_DEPTH) begin
      res = LEN_W'(WINDOW_DEPTH);
    end else begin
      res = LEN_W'(v);
    end
    return res;
  endfunction

endpackage

// File: hdl/sma_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module sma_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sma_div.sv
// Restoring divider: one quotient bit per cycle, for a window sum by a length.
module sma_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sma_pkg::div_req_t             req,
  output sma_pkg::div_sts_t             sts,
  output logic [sma_pkg::SUM_W-1:0]     quotient
);

  logic                            busy_r;
  logic                            done_r;
  logic [sma_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [sma_pkg::SUM_W-1:0]       quo_r;
  logic [sma_pkg::LEN_W-1:0]       rem_r;
  logic [sma_pkg::LEN_W-1:0]       div_r;
  logic [sma_pkg::LEN_W:0]         trial;
  logic [sma_pkg::LEN_W-1:0]       rem_nxt;
  logic                            qbit;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[sma_pkg::SUM_W-1]};
    if (trial >= {1'b0, div_r}) begin
      qbit    = 1'b1;
      rem_nxt = sma_pkg::LEN_W'(trial - {1'b0, div_r});
    end else begin
      qbit    = 1'b0;
      rem_nxt = trial[sma_pkg::LEN_W-1:0];
    end
  end

  // Control: busy while the quotient bits are worked out, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= sma_pkg::DIV_CNT_W'(sma_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == sma_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of the top as quotient bits enter below.
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[sma_pkg::SUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/sma_crossover_detector.sv
// Top level: moving average crossover detector with window RAM and shared divider.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    in_price
//   out_     output     out_valid / out_stall  averages, valid flag, cross flags
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes through the states ST_SUM, ST_DIV_S, ST_DIV_L and ST_OUT in turn; the
// sum pass reads the newest N entries, N being the larger of the lengths whose windows
// are full. The sum pass reads the RAM one entry a cycle, and the two divisions share
// one bit-serial divider.
// Reset is synchronous and active low; it needs no clearing pass.
// A held result in the output register stalls only the final write-back.
`include "sma_crossover_detector_assert.svh"

module sma_crossover_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  // Price input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sma_pkg::PRICE_BITS-1:0]     in_price,
  // Result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sma_pkg::PRICE_BITS-1:0]     out_short_average,
  output logic [sma_pkg::PRICE_BITS-1:0]     out_long_average,
  output logic                               out_averages_valid,
  output logic                               out_rise_cross,
  output logic                               out_fall_cross,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [sma_pkg::CFG_W-1:0]          cfg_data
);

  sma_pkg::state_t                   state_r, state_nxt;
  logic [sma_pkg::CFG_W-1:0]         short_len_r, long_len_r;
  logic [sma_pkg::ADDR_W-1:0]        head_r;
  logic [sma_pkg::LEN_W-1:0]         count_r;
  logic [sma_pkg::LEN_W-1:0]         s_n_r, l_n_r, n_max_r;
  logic [sma_pkg::LEN_W-1:0]         rd_k_r;
  logic [sma_pkg::ADDR_W-1:0]        rd_addr_r;
  logic                              rd_vld_r;
  logic [sma_pkg::LEN_W-1:0]         rd_idx_r;
  logic [sma_pkg::SUM_W-1:0]         s_acc_r, l_acc_r;
  logic [sma_pkg::PRICE_BITS-1:0]    s_avg_r, l_avg_r;
  logic                              valid_r;
  logic [sma_pkg::PRICE_BITS-1:0]    prev_s_r, prev_l_r;
  logic                              prev_valid_r;
  logic                              out_valid_r;
  logic [sma_pkg::PRICE_BITS-1:0]    out_short_average_r, out_long_average_r;
  logic                              out_averages_valid_r;
  logic                              out_rise_cross_r, out_fall_cross_r;

  logic                              in_take;
  logic                              out_load;
  logic                              rd_issue;
  logic [sma_pkg::LEN_W-1:0]         count_nxt;
  logic [sma_pkg::LEN_W-1:0]         slen_c, llen_c, s_n_c, l_n_c;
  logic [sma_pkg::PRICE_BITS-1:0]    ram_rdata;
  logic                              bull_c, bear_c;
  sma_pkg::div_req_t                 div_req;
  sma_pkg::div_sts_t                 div_sts;
  logic [sma_pkg::SUM_W-1:0]         div_quo;

  assign in_stall  = (state_r != sma_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Window lengths for the incoming sample; a window not yet full counts as empty.
  always_comb begin
    count_nxt = (int'(count_r) < sma_pkg::WINDOW_DEPTH) ? count_r + 1'b1 : count_r;
    slen_c    = sma_pkg::clamp_len(short_len_r);
    llen_c    = sma_pkg::clamp_len(long_len_r);
    s_n_c     = (count_nxt >= slen_c) ? slen_c : '0;
    l_n_c     = (count_nxt >= llen_c) ? llen_c : '0;
  end

  assign rd_issue = (state_r == sma_pkg::ST_SUM) && (rd_k_r < n_max_r);

  // Window storage.
  sma_ram #(
    .DEPTH  (sma_pkg::WINDOW_DEPTH),
    .WIDTH  (sma_pkg::PRICE_BITS),
    .ADDR_W (sma_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (in_take),
    .waddr (head_r),
    .wdata (in_price),
    .re    (rd_issue),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Shared divider.
  sma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // Crossing flags of the result being written back.
  always_comb begin
    bull_c = valid_r && prev_valid_r && (s_avg_r > l_avg_r) && (prev_s_r <= prev_l_r);
    bear_c = valid_r && prev_valid_r && (s_avg_r < l_avg_r) && (prev_s_r >= prev_l_r);
  end

  // Next state and divider requests.
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = s_acc_r;
    div_req.divisor  = slen_c;
    out_load         = 1'b0;
    unique case (state_r)
      sma_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = sma_pkg::ST_SUM;
        end
      end
      sma_pkg::ST_SUM: begin
        if ((rd_k_r == n_max_r) && !rd_vld_r) begin
          div_req.start = 1'b1;
          state_nxt     = sma_pkg::ST_DIV_S;
        end
      end
      sma_pkg::ST_DIV_S: begin
        if (div_sts.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = l_acc_r;
          div_req.divisor  = llen_c;
          state_nxt        = sma_pkg::ST_DIV_L;
        end
      end
      sma_pkg::ST_DIV_L: begin
        if (div_sts.done) begin
          state_nxt = sma_pkg::ST_OUT;
        end
      end
      sma_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sma_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sma_pkg::ST_IDLE;
      short_len_r  <= sma_pkg::CFG_W'(3);
      long_len_r   <= sma_pkg::CFG_W'(7);
      head_r       <= '0;
      count_r      <= '0;
      rd_k_r       <= '0;
      rd_vld_r     <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_s_r     <= '0;
      prev_l_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sma_pkg::REG_SHORT_LENGTH: short_len_r <= cfg_data;
          sma_pkg::REG_LONG_LENGTH:  long_len_r  <= cfg_data;
          default: ;
        endcase
      end

      // New sample: advance the head and the fill count.
      if (in_take) begin
        head_r  <= (head_r == sma_pkg::ADDR_W'(sma_pkg::WINDOW_DEPTH - 1)) ?
                   '0 : head_r + 1'b1;
        count_r <= count_nxt;
        rd_k_r  <= '0;
      end else if (rd_issue) begin
        rd_k_r <= rd_k_r + 1'b1;
      end
      rd_vld_r <= rd_issue;

      // Result write-back and history update.
      if (out_load) begin
        out_valid_r  <= 1'b1;
        prev_s_r     <= s_avg_r;
        prev_l_r     <= l_avg_r;
        prev_valid_r <= valid_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Start the sum pass at the newest sample and walk backward.
    if (in_take) begin
      s_n_r     <= s_n_c;
      l_n_r     <= l_n_c;
      n_max_r   <= (s_n_c > l_n_c) ? s_n_c : l_n_c;
      valid_r   <= (s_n_c != '0) && (l_n_c != '0);
      rd_addr_r <= head_r;
      s_acc_r   <= '0;
      l_acc_r   <= '0;
    end else begin
      if (rd_issue) begin
        rd_addr_r <= (rd_addr_r == '0) ?
                     sma_pkg::ADDR_W'(sma_pkg::WINDOW_DEPTH - 1) : rd_addr_r - 1'b1;
      end
      if (rd_vld_r) begin
        if (rd_idx_r < s_n_r) begin
          s_acc_r <= s_acc_r + sma_pkg::SUM_W'(ram_rdata);
        end
        if (rd_idx_r < l_n_r) begin
          l_acc_r <= l_acc_r + sma_pkg::SUM_W'(ram_rdata);
        end
      end
    end
    rd_idx_r <= rd_k_r;

    // Capture quotients.
    if ((state_r == sma_pkg::ST_DIV_S) && div_sts.done) begin
      s_avg_r <= div_quo[sma_pkg::PRICE_BITS-1:0];
    end
    if ((state_r == sma_pkg::ST_DIV_L) && div_sts.done) begin
      l_avg_r <= div_quo[sma_pkg::PRICE_BITS-1:0];
    end

    // Output register.
    if (out_load) begin
      out_short_average_r  <= s_avg_r;
      out_long_average_r   <= l_avg_r;
      out_averages_valid_r <= valid_r;
      out_rise_cross_r     <= bull_c;
      out_fall_cross_r     <= bear_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_short_average  = out_short_average_r;
  assign out_long_average   = out_long_average_r;
  assign out_averages_valid = out_averages_valid_r;
  assign out_rise_cross     = out_rise_cross_r;
  assign out_fall_cross     = out_fall_cross_r;

  // Checks on the crossing flags, the window read pass and the divider start.
  `SMA_ASSERT_NOW(a_cross_exclusive, out_valid_r,
                  !(out_rise_cross_r && out_fall_cross_r), "both crosses flagged")
  `SMA_ASSERT_NOW(a_cross_needs_valid, out_valid_r && (out_rise_cross_r || out_fall_cross_r),
                  out_averages_valid_r, "cross flagged without valid averages")
  `SMA_ASSERT_NOW(a_read_count_bound, state_r == sma_pkg::ST_SUM,
                  rd_k_r <= n_max_r, "sum pass read past its length")
  `SMA_ASSERT_NOW(a_reads_written_only, state_r == sma_pkg::ST_SUM,
                  n_max_r <= count_r, "sum pass reaches unwritten entries")
  `SMA_ASSERT_NEXT(a_div_start_idle, div_req.start && !div_sts.busy,
                   div_sts.busy, "divider did not start")

endmodule

// File: tb/tb_sma_crossover_detector.sv
// Self-checking testbench for the moving average crossover detector.
`timescale 1ns / 100ps

module tb_sma_crossover_detector;

  localparam int PW    = sma_pkg::PRICE_BITS;
  localparam int DEPTH = sma_pkg::WINDOW_DEPTH;
  localparam int AW    = sma_pkg::ADDR_W;
  localparam int CW    = sma_pkg::CFG_W;
  localparam int ITEMS = 1350;

  typedef logic [PW-1:0] price_t;
  typedef logic [CW-1:0] len_reg_t;

  localparam price_t PMAX = '1;

  // One result item of the detector.
  typedef struct {
    price_t short_avg;
    price_t long_avg;
    logic   avg_ok;
    logic   bull;
    logic   bear;
  } crossover_t;

  // Ways of making the next price of a burst.
  typedef enum int {
    SRC_WALK,
    SRC_NOISE,
    SRC_EXTREME,
    SRC_TOP
  } price_source_t;

  // Keeps its own copy of the price history and the lengths, and predicts
  // the averages and cross flags of every accepted price.
  class crossover_scoreboard;
    price_t        history [DEPTH];
    logic [AW-1:0] head;
    int            fill;
    price_t        last_short;
    price_t        last_long;
    bit            last_ok;
    len_reg_t      short_reg;
    len_reg_t      long_reg;
    crossover_t    pending_q [$];
    int            errors;

    function new();
      foreach (history[i]) history[i] = '0;
      head       = '0;
      fill       = 0;
      last_short = '0;
      last_long  = '0;
      last_ok    = 1'b0;
      short_reg  = len_reg_t'(3);
      long_reg   = len_reg_t'(7);
      errors     = 0;
    endfunction

    function void write_reg(logic [0:0] idx, len_reg_t v);
      if (idx == sma_pkg::REG_SHORT_LENGTH) begin
        short_reg = v;
      end else begin
        long_reg = v;
      end
    endfunction

    // Zero counts as one; anything past the window depth as the depth.
    function int used_len(len_reg_t v);
      if (v == '0) return 1;
      if (int'(v) > DEPTH) return DEPTH;
      return int'(v);
    endfunction

    // Sum of the newest len prices, walking back from the write slot.
    function logic [63:0] newest_sum(int len);
      logic [AW-1:0] idx;
      logic [63:0]   acc;
      idx = head;
      acc = '0;
      for (int k = 0; k < len; k++) begin
        idx = idx - 1'b1;
        acc += 64'(history[idx]);
      end
      return acc;
    endfunction

    function void note_price(price_t p);
      int         slen;
      int         llen;
      bit         s_full;
      bit         l_full;
      crossover_t want;
      history[head] = p;
      head = head + 1'b1;
      if (fill < DEPTH) fill++;
      slen   = used_len(short_reg);
      llen   = used_len(long_reg);
      s_full = fill >= slen;
      l_full = fill >= llen;
      want.short_avg = s_full ? price_t'(newest_sum(slen) / 64'(slen)) : '0;
      want.long_avg  = l_full ? price_t'(newest_sum(llen) / 64'(llen)) : '0;
      want.avg_ok    = s_full && l_full;
      // A cross needs valid averages on this sample and the one before.
      want.bull = want.avg_ok && last_ok && (want.short_avg > want.long_avg) &&
                  (last_short <= last_long);
      want.bear = want.avg_ok && last_ok && (want.short_avg < want.long_avg) &&
                  (last_short >= last_long);
      last_short = want.short_avg;
      last_long  = want.long_avg;
      last_ok    = want.avg_ok;
      pending_q.insert(pending_q.size(), want);
    endfunction

    function void cmp_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(crossover_t got);
      crossover_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result item with no price waiting for it", $time);
        return;
      end
      want = pending_q.pop_front();
      cmp_field("short_average", 64'(want.short_avg), 64'(got.short_avg));
      cmp_field("long_average", 64'(want.long_avg), 64'(got.long_avg));
      cmp_field("averages_valid", 64'(want.avg_ok), 64'(got.avg_ok));
      cmp_field("rise_cross", 64'(want.bull), 64'(got.bull));
      cmp_field("fall_cross", 64'(want.bear), 64'(got.bear));
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  price_t     in_price = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  price_t     out_short_average;
  price_t     out_long_average;
  logic       out_averages_valid;
  logic       out_rise_cross;
  logic       out_fall_cross;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = sma_pkg::REG_SHORT_LENGTH;
  len_reg_t   cfg_data = '0;

  crossover_scoreboard sb;

  // Random walk state shared by the bursts of one phase.
  price_t walk_price;
  bit     walk_up;
  int     walk_shift;

  // Receiver stall pattern state.
  int rx_mode = 0;
  int rx_hold = 0;

  sma_crossover_detector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_price          (in_price),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_short_average (out_short_average),
    .out_long_average  (out_long_average),
    .out_averages_valid(out_averages_valid),
    .out_rise_cross    (out_rise_cross),
    .out_fall_cross    (out_fall_cross),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall: switches among free flow, light, heavy and long stalls.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_hold <= $urandom_range(20, 400);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= (rx_hold[5:4] != 2'b00);
    endcase
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    crossover_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.short_avg = out_short_average;
      seen.long_avg  = out_long_average;
      seen.avg_ok    = out_averages_valid;
      seen.bull      = out_rise_cross;
      seen.bear      = out_fall_cross;
      sb.check_result(seen);
    end
  end

  // Offers one price and holds it until the detector takes it.
  task automatic send_price(price_t p);
    in_valid <= 1'b1;
    in_price <= p;
    do @(posedge clk); while (in_stall);
    sb.note_price(p);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_reg(logic [0:0] idx, len_reg_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic len_reg_t pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return len_reg_t'(1);
      2: return len_reg_t'(DEPTH);
      3: return len_reg_t'($urandom_range(DEPTH + 1, 127));
      default: return len_reg_t'($urandom_range(1, DEPTH));
    endcase
  endfunction

  function automatic price_t next_price(price_source_t src);
    price_t step;
    case (src)
      SRC_WALK: begin
        if ($urandom_range(0, 5) == 0) walk_up = !walk_up;
        step = price_t'({$urandom(), $urandom()}) >> walk_shift;
        // Flat stretches make the averages meet exactly.
        if ($urandom_range(0, 7) == 0) step = '0;
        if (walk_up) begin
          walk_price = (walk_price > PMAX - step) ? PMAX : walk_price + step;
        end else begin
          walk_price = (walk_price < step) ? '0 : walk_price - step;
        end
        return walk_price;
      end
      SRC_NOISE: return price_t'({$urandom(), $urandom()});
      SRC_TOP: return PMAX - price_t'($urandom_range(0, 3));
      default: return ($urandom_range(0, 3) == 0) ? '0 : PMAX;
    endcase
  endfunction

  initial begin
    price_t        opening [17];
    len_reg_t      short_plan [7];
    len_reg_t      long_plan [7];
    int            sent;
    int            phase;
    int            items_now;
    int            phase_items;
    int            burst;
    int            gap;
    int            r;
    price_source_t src;

    opening = '{price_t'(100), price_t'(100), price_t'(100), price_t'(100),
                price_t'(100), price_t'(100), price_t'(100), price_t'(1000),
                price_t'(1000), price_t'(1000), '0, '0, '0, PMAX, PMAX, PMAX, '0};
    short_plan = '{len_reg_t'(1), len_reg_t'(64), len_reg_t'(0), len_reg_t'(64),
                   len_reg_t'(1), len_reg_t'(127), len_reg_t'(2)};
    long_plan  = '{len_reg_t'(64), len_reg_t'(1), len_reg_t'(127), len_reg_t'(64),
                   len_reg_t'(1), len_reg_t'(0), len_reg_t'(2)};
    sb = new();
    walk_price = '0;
    walk_up    = 1'b1;
    walk_shift = 30;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default lengths: windows filling up, first valid pair, then a rising
    // and a falling cross, and the price extremes.
    foreach (opening[i]) send_price(opening[i]);
    drain();

    // Out-of-range lengths with the history kept: long of one, short clamped.
    write_reg(sma_pkg::REG_SHORT_LENGTH, len_reg_t'(127));
    write_reg(sma_pkg::REG_LONG_LENGTH, '0);
    send_price(PMAX);
    send_price('0);
    send_price(PMAX);
    send_price(price_t'(1));

    // Random phases; lengths written while idle, the long one every phase.
    sent  = 0;
    phase = 0;
    while (sent < ITEMS) begin
      drain();
      if (phase < 7) begin
        write_reg(sma_pkg::REG_SHORT_LENGTH, short_plan[phase]);
        write_reg(sma_pkg::REG_LONG_LENGTH, long_plan[phase]);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(sma_pkg::REG_SHORT_LENGTH, pick_len());
        write_reg(sma_pkg::REG_LONG_LENGTH, pick_len());
      end
      walk_price  = price_t'({$urandom(), $urandom()}) >> $urandom_range(0, 36);
      walk_shift  = $urandom_range(4, 36);
      phase_items = $urandom_range(60, 140);
      items_now   = 0;
      while (items_now < phase_items) begin
        burst = $urandom_range(1, 40);
        r = $urandom_range(0, 19);
        if (phase == 3) begin
          // Full windows of the largest prices push the sums to their top.
          src = SRC_TOP;
        end else if (r < 15) begin
          src = SRC_WALK;
        end else if (r < 17) begin
          src = SRC_NOISE;
        end else begin
          src = SRC_EXTREME;
        end
        for (int k = 0; k < burst; k++) begin
          send_price(next_price(src));
        end
        items_now += burst;
        r = $urandom_range(0, 9);
        if (r < 4) begin
          gap = 0;
        end else if (r < 8) begin
          gap = $urandom_range(1, 20);
        end else begin
          gap = $urandom_range(21, 200);
        end
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      sent += items_now;
      phase++;
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_sma_crossover_detector passed");
    end else begin
      $display("tb_sma_crossover_detector failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #30_000_000;
    $display("tb_sma_crossover_detector failed");
    $finish;
  end

endmodule
